### hw/rtl/hal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hal_pkg: heard address table package
// Shared types, commands, state codes and widths of the heard address table.
// ----------------------------------------------------------------------------
package hal_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int CAP_W         = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic CAP_REG_IDX = 1'b0;

  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 4;
  localparam int SEC_W   = 32;
  localparam int CNT_W   = 32;
  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 104;

  typedef enum logic [1:0] {
    CMD_LOG   = 2'd0,
    CMD_FLUSH = 2'd1,
    CMD_LIST  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOG_RD,
    ST_LOG_SLOT,
    ST_LOG_CMP,
    ST_LOG_FIN,
    ST_LIST_RD,
    ST_LIST_SLOT,
    ST_LIST_EMIT
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    logic [SEC_W-1:0]  stamp;
    logic [CNT_W-1:0]  count;
  } slot_t;

  typedef struct packed {
    logic              entry_valid;
    logic [ADDR_W-1:0] entry_addr;
    logic [PORT_W-1:0] entry_port;
    logic [SEC_W-1:0]  age_sec;
    logic [CNT_W-1:0]  pkt_count;
    logic              was_hit;
    logic              was_evicted;
    logic              is_last;
  } res_t;

endpackage

### hw/rtl/hal_order_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hal_order_ram: recency order memory
// Slot numbers by position, one write and one registered read per cycle.
// Entries not yet written since reset or flush read as their own position.
// ----------------------------------------------------------------------------
module hal_order_ram #(
  parameter int DEPTH = hal_pkg::DEPTH_DEFAULT,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  logic [IDX_W-1:0] wdata_i,
  input  logic             re_i,
  input  logic [IDX_W-1:0] raddr_i,
  output logic [IDX_W-1:0] rdata_o
);

  logic [IDX_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [IDX_W-1:0] rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_i) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= valid_q[raddr_i] ? mem[raddr_i] : raddr_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/hal_slot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hal_slot_ram: slot storage
// Address, port, time stamp and count per slot; one write, one registered read.
// ----------------------------------------------------------------------------
module hal_slot_ram #(
  parameter int DEPTH = hal_pkg::DEPTH_DEFAULT,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  hal_pkg::slot_t   wdata_i,
  input  logic             re_i,
  input  logic [IDX_W-1:0] raddr_i,
  output hal_pkg::slot_t   rdata_o
);

  hal_pkg::slot_t mem [DEPTH];
  hal_pkg::slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/hal_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hal_engine: table walk sequencer
// Walks the recency order one position at a time with a shared comparator
// and a shared add/subtract unit; moves entries to the front and holds
// one finished result word in an output register.
// ----------------------------------------------------------------------------
module hal_engine #(
  parameter int DEPTH = hal_pkg::DEPTH_DEFAULT,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int OCC_W = $clog2(DEPTH + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  hal_pkg::cmd_e              in_cmd_i,
  input  logic [hal_pkg::ADDR_W-1:0] in_addr_i,
  input  logic [hal_pkg::PORT_W-1:0] in_port_i,
  input  logic [hal_pkg::SEC_W-1:0]  in_now_i,
  input  logic [OCC_W-1:0]           lim_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output hal_pkg::res_t              out_res_o,
  output logic                       ord_clear_o,
  output logic                       ord_we_o,
  output logic [IDX_W-1:0]           ord_waddr_o,
  output logic [IDX_W-1:0]           ord_wdata_o,
  output logic                       ord_re_o,
  output logic [IDX_W-1:0]           ord_raddr_o,
  input  logic [IDX_W-1:0]           ord_rdata_i,
  output logic                       slot_we_o,
  output logic [IDX_W-1:0]           slot_waddr_o,
  output hal_pkg::slot_t             slot_wdata_o,
  output logic                       slot_re_o,
  output logic [IDX_W-1:0]           slot_raddr_o,
  input  hal_pkg::slot_t             slot_rdata_i
);

  hal_pkg::state_e state_q, state_d;
  logic [OCC_W-1:0] pos_q, pos_d;
  logic [OCC_W-1:0] occ_q, occ_d;
  logic [IDX_W-1:0] carry_q, carry_d;
  logic [IDX_W-1:0] s_q, s_d;
  logic [IDX_W-1:0] front_q, front_d;
  logic             hit_q, hit_d;
  logic             evict_q, evict_d;

  logic [hal_pkg::ADDR_W-1:0] addr_q;
  logic [hal_pkg::PORT_W-1:0] port_q;
  logic [hal_pkg::SEC_W-1:0]  now_q;

  logic                     out_valid_q;
  hal_pkg::res_t            out_res_q;
  hal_pkg::res_t            res;
  logic                     emit;
  logic                     out_free;

  logic [31:0] alu_a, alu_b, alu_y;
  logic        alu_sub;

  logic [OCC_W-1:0] pos_inc;
  logic [IDX_W-1:0] pos_idx;

  assign out_free = !out_valid_q || out_ready_i;
  assign pos_inc  = pos_q + OCC_W'(1);
  assign pos_idx  = pos_q[IDX_W-1:0];
  assign alu_y    = alu_a + (alu_sub ? ~alu_b : alu_b) + {31'b0, alu_sub};

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    occ_d   = occ_q;
    carry_d = carry_q;
    s_d     = s_q;
    front_d = front_q;
    hit_d   = hit_q;
    evict_d = evict_q;

    in_ready_o   = 1'b0;
    ord_clear_o  = 1'b0;
    ord_we_o     = 1'b0;
    ord_waddr_o  = pos_idx;
    ord_wdata_o  = carry_q;
    ord_re_o     = 1'b0;
    ord_raddr_o  = pos_idx;
    slot_we_o    = 1'b0;
    slot_waddr_o = front_q;
    slot_re_o    = 1'b0;
    slot_raddr_o = ord_rdata_i;

    alu_a   = slot_rdata_i.count;
    alu_b   = 32'd1;
    alu_sub = 1'b0;

    slot_wdata_o.addr  = addr_q;
    slot_wdata_o.port  = port_q;
    slot_wdata_o.stamp = now_q;
    slot_wdata_o.count = 32'd1;

    emit = 1'b0;
    res  = '0;

    case (state_q)
      hal_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_cmd_i)
            hal_pkg::CMD_LOG: begin
              pos_d   = '0;
              state_d = hal_pkg::ST_LOG_RD;
            end
            hal_pkg::CMD_FLUSH: begin
              occ_d       = '0;
              ord_clear_o = 1'b1;
            end
            hal_pkg::CMD_LIST: begin
              pos_d   = '0;
              state_d = hal_pkg::ST_LIST_RD;
            end
            default: ;
          endcase
        end
      end

      hal_pkg::ST_LOG_RD: begin
        if (pos_q == occ_q && occ_q >= lim_i) begin
          front_d = carry_q;
          hit_d   = 1'b0;
          evict_d = 1'b1;
          state_d = hal_pkg::ST_LOG_FIN;
        end else begin
          ord_re_o = 1'b1;
          state_d  = hal_pkg::ST_LOG_SLOT;
        end
      end

      hal_pkg::ST_LOG_SLOT: begin
        if (pos_q == occ_q) begin
          ord_we_o = (pos_q != '0);
          front_d  = ord_rdata_i;
          hit_d    = 1'b0;
          evict_d  = 1'b0;
          occ_d    = pos_inc;
          state_d  = hal_pkg::ST_LOG_FIN;
        end else begin
          slot_re_o = 1'b1;
          s_d       = ord_rdata_i;
          state_d   = hal_pkg::ST_LOG_CMP;
        end
      end

      hal_pkg::ST_LOG_CMP: begin
        ord_we_o = (pos_q != '0);
        carry_d  = s_q;
        if (slot_rdata_i.addr == addr_q) begin
          front_d = s_q;
          hit_d   = 1'b1;
          evict_d = 1'b0;
          state_d = hal_pkg::ST_LOG_FIN;
        end else begin
          pos_d   = pos_inc;
          state_d = hal_pkg::ST_LOG_RD;
        end
      end

      hal_pkg::ST_LOG_FIN: begin
        if (hit_q) begin
          slot_wdata_o.count = (slot_rdata_i.count == '1) ? slot_rdata_i.count : alu_y;
        end
        ord_waddr_o = '0;
        ord_wdata_o = front_q;
        res.entry_valid = 1'b1;
        res.entry_addr  = addr_q;
        res.entry_port  = port_q;
        res.pkt_count   = slot_wdata_o.count;
        res.was_hit     = hit_q;
        res.was_evicted = evict_q;
        res.is_last     = 1'b1;
        if (out_free) begin
          ord_we_o  = 1'b1;
          slot_we_o = 1'b1;
          emit      = 1'b1;
          state_d   = hal_pkg::ST_IDLE;
        end
      end

      hal_pkg::ST_LIST_RD: begin
        if (occ_q == '0) begin
          res.is_last = 1'b1;
          if (out_free) begin
            emit    = 1'b1;
            state_d = hal_pkg::ST_IDLE;
          end
        end else begin
          ord_re_o = 1'b1;
          state_d  = hal_pkg::ST_LIST_SLOT;
        end
      end

      hal_pkg::ST_LIST_SLOT: begin
        slot_re_o = 1'b1;
        state_d   = hal_pkg::ST_LIST_EMIT;
      end

      hal_pkg::ST_LIST_EMIT: begin
        alu_a   = now_q;
        alu_b   = slot_rdata_i.stamp;
        alu_sub = 1'b1;
        res.entry_valid = 1'b1;
        res.entry_addr  = slot_rdata_i.addr;
        res.entry_port  = slot_rdata_i.port;
        res.age_sec     = alu_y;
        res.pkt_count   = slot_rdata_i.count;
        res.is_last     = (pos_inc == occ_q);
        if (out_free) begin
          emit = 1'b1;
          if (pos_inc == occ_q) begin
            state_d = hal_pkg::ST_IDLE;
          end else begin
            pos_d   = pos_inc;
            state_d = hal_pkg::ST_LIST_RD;
          end
        end
      end

      default: state_d = hal_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hal_pkg::ST_IDLE;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    carry_q <= carry_d;
    s_q     <= s_d;
    front_q <= front_d;
    hit_q   <= hit_d;
    evict_q <= evict_d;
    if (in_valid_i && in_ready_o) begin
      addr_q <= in_addr_i;
      port_q <= in_port_i;
      now_q  <= in_now_i;
    end
    if (emit) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

### hw/rtl/heard_address_lru_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heard_address_lru_table: heard source address table, most recent first
// Log: take the word, then an order read, slot read and compare per entry;
// a hit goes to the final step, an eviction from the order read step and a
// new entry from the slot step. List: take the word, then an order read, slot
// read and emit per entry; an empty table only emits. Flush and unknown
// commands end on acceptance. Hold the final step while the output stalls.
// Reset: table empty, identity order, limit 16; no clearing pass is needed.
// ----------------------------------------------------------------------------
module heard_address_lru_table #(
  parameter int TABLE_DEPTH = hal_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: src_addr[31:0], port_index[35:32], now_sec[67:36], zero[71:68]
  input  logic [hal_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // tuser: cmd[1:0]
  input  logic [1:0]                    s_axis_tuser_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata: entry_addr[31:0], entry_port[35:32], age_sec[67:36],
  //        pkt_count[99:68], was_hit[100], was_evicted[101], zero[103:102]
  output logic [hal_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  // tuser: entry_valid[0]
  output logic [0:0]                    m_axis_tuser_o,
  output logic                          m_axis_tlast_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int OCC_W = $clog2(TABLE_DEPTH + 1);
  localparam int LIM_W = (OCC_W > hal_pkg::CAP_W) ? OCC_W : hal_pkg::CAP_W;

  logic [hal_pkg::CAP_W-1:0] cap_q;
  logic [LIM_W-1:0]          cap_ext;
  logic [OCC_W-1:0]          lim;

  logic             ord_clear, ord_we, ord_re;
  logic [IDX_W-1:0] ord_waddr, ord_wdata, ord_raddr, ord_rdata;
  logic             slot_we, slot_re;
  logic [IDX_W-1:0] slot_waddr, slot_raddr;
  hal_pkg::slot_t   slot_wdata, slot_rdata;
  hal_pkg::res_t    res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= hal_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == hal_pkg::CAP_REG_IDX) begin
      cap_q <= pwdata[hal_pkg::CAP_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == hal_pkg::CAP_REG_IDX) ? {27'b0, cap_q} : 32'b0;

  assign cap_ext = LIM_W'(cap_q);
  assign lim = (cap_q == '0 || cap_ext > LIM_W'(TABLE_DEPTH)) ?
               OCC_W'(TABLE_DEPTH) : OCC_W'(cap_ext);

  hal_order_ram #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_order (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (ord_clear),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .re_i    (ord_re),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  hal_slot_ram #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_slot (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  hal_engine #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W),
    .OCC_W (OCC_W)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_cmd_i     (hal_pkg::cmd_e'(s_axis_tuser_i)),
    .in_addr_i    (s_axis_tdata_i[31:0]),
    .in_port_i    (s_axis_tdata_i[35:32]),
    .in_now_i     (s_axis_tdata_i[67:36]),
    .lim_i        (lim),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_res_o    (res),
    .ord_clear_o  (ord_clear),
    .ord_we_o     (ord_we),
    .ord_waddr_o  (ord_waddr),
    .ord_wdata_o  (ord_wdata),
    .ord_re_o     (ord_re),
    .ord_raddr_o  (ord_raddr),
    .ord_rdata_i  (ord_rdata),
    .slot_we_o    (slot_we),
    .slot_waddr_o (slot_waddr),
    .slot_wdata_o (slot_wdata),
    .slot_re_o    (slot_re),
    .slot_raddr_o (slot_raddr),
    .slot_rdata_i (slot_rdata)
  );

  assign m_axis_tdata_o = {2'b0, res.was_evicted, res.was_hit, res.pkt_count,
                           res.age_sec, res.entry_port, res.entry_addr};
  assign m_axis_tuser_o = res.entry_valid;
  assign m_axis_tlast_o = res.is_last;

endmodule
